@@ rtl/sard_pkg.sv @@
// Package with shared widths, defaults, state codes and cell control types.
package sard_pkg;

  localparam int ValueWidth = 32;
  localparam int MaxItemsDefault = 64;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/sard_cell.sv @@
// One cell of the sorting chain: holds one value and trades it with its neighbors.
module sard_cell (
  input  logic                                     clk,
  input  logic                                     rst,
  input  sard_pkg::cell_ctrl_t                     ctrl,
  input  logic signed [sard_pkg::ValueWidth-1:0]   ins_value,
  input  logic                                     left_valid,
  input  logic                                     left_take,
  input  logic signed [sard_pkg::ValueWidth-1:0]   left_value,
  input  logic                                     right_valid,
  input  logic signed [sard_pkg::ValueWidth-1:0]   right_value,
  output logic                                     take,
  output logic                                     valid,
  output logic signed [sard_pkg::ValueWidth-1:0]   stored
);

  assign take = ctrl.insert && (valid ? (ins_value < stored) : left_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stored <= left_take ? left_value : ins_value;
    end else if (ctrl.shift) begin
      stored <= right_value;
    end
  end

endmodule

@@ rtl/sort_and_remove_duplicates_core.sv @@
// Top level: a chain of sorting cells with insertion, drain and duplicate removal.
// Each accepted value is inserted into the sorted chain at the edge that accepts it, unless full.
// After the flagged item, busy stays high while the stored values drain.
// Each drained value passes through pend_value and then the registered outputs; the final
// result strobes once busy has fallen, and at most one result is given per cycle.
// Synchronous reset empties the chain and clears the count, the seen-overflow flag and the strobe.
module sort_and_remove_duplicates_core #(
  parameter int MaxItems = sard_pkg::MaxItemsDefault
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [sard_pkg::ValueWidth-1:0]   value,
  input  logic                                     last_in,
  output logic                                     strobe,
  output logic signed [sard_pkg::ValueWidth-1:0]   distinct_value,
  output logic                                     last_out,
  output logic                                     overflow
);

  localparam int CountW = $clog2(MaxItems + 1);

  sard_pkg::state_t state, state_next;
  sard_pkg::cell_ctrl_t ctrl;

  logic [CountW-1:0] item_count;
  logic overflow_seen;
  logic set_overflow;
  logic pend_valid;
  logic signed [sard_pkg::ValueWidth-1:0] pend_value;

  logic accept;
  logic full;
  logic head_valid;
  logic signed [sard_pkg::ValueWidth-1:0] head_value;
  logic emit;

  logic cell_take [MaxItems];
  logic cell_valid [MaxItems];
  logic signed [sard_pkg::ValueWidth-1:0] cell_value [MaxItems];

  assign full   = (item_count == CountW'(MaxItems));
  assign accept = start && !busy;
  assign head_valid = cell_valid[0];
  assign head_value = cell_value[0];

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    logic left_valid;
    logic left_take;
    logic signed [sard_pkg::ValueWidth-1:0] left_value;
    logic right_valid;
    logic signed [sard_pkg::ValueWidth-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_take  = 1'b0;
      assign left_value = value;
    end else begin : g_inner_left
      assign left_valid = cell_valid[i-1];
      assign left_take  = cell_take[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == MaxItems - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_value = cell_value[i];
    end else begin : g_inner_right
      assign right_valid = cell_valid[i+1];
      assign right_value = cell_value[i+1];
    end

    sard_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .ins_value   (value),
      .left_valid  (left_valid),
      .left_take   (left_take),
      .left_value  (left_value),
      .right_valid (right_valid),
      .right_value (right_value),
      .take        (cell_take[i]),
      .valid       (cell_valid[i]),
      .stored      (cell_value[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      sard_pkg::ST_IDLE: begin
        if (accept && last_in) begin
          state_next = sard_pkg::ST_DRAIN;
        end
      end
      sard_pkg::ST_DRAIN: begin
        if (!head_valid) begin
          state_next = sard_pkg::ST_IDLE;
        end
      end
      default: state_next = sard_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    emit        = 1'b0;
    case (state)
      sard_pkg::ST_IDLE: begin
        ctrl.insert = accept && !full;
      end
      sard_pkg::ST_DRAIN: begin
        busy       = 1'b1;
        ctrl.shift = head_valid;
        emit       = head_valid ? (pend_valid && (head_value != pend_value)) : pend_valid;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sard_pkg::ST_IDLE;
      item_count    <= '0;
      overflow_seen <= 1'b0;
      pend_valid    <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (accept) begin
        if (last_in) begin
          item_count    <= '0;
          overflow_seen <= 1'b0;
        end else if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          item_count <= item_count + CountW'(1);
        end
      end
      if (state == sard_pkg::ST_DRAIN) begin
        pend_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_in) begin
      set_overflow <= overflow_seen || full;
    end
    if (state == sard_pkg::ST_DRAIN && head_valid) begin
      pend_value <= head_value;
    end
    if (emit) begin
      distinct_value <= pend_value;
      last_out       <= !head_valid;
      overflow       <= set_overflow;
    end
  end

endmodule

@@ rtl/sard_checker.sv @@
// Port-level checker for the sort core, with its bind statement.
module sard_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    busy,
  input logic                                    strobe,
  input logic signed [sard_pkg::ValueWidth-1:0]  distinct_value,
  input logic                                    last_out,
  input logic                                    overflow
);

  a_beat_while_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  a_final_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_out) |-> !busy)
    else $error("busy still high on the final result beat");

  a_inner_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_out) |-> busy)
    else $error("non-final result beat while idle");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_out) |=> (!strobe || (distinct_value > $past(distinct_value))))
    else $error("result values not strictly ascending");

  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_out) |=> (!strobe || (overflow == $past(overflow))))
    else $error("overflow flag changed within a set");

endmodule

bind sort_and_remove_duplicates_core sard_checker u_sard_checker (.*);
